// ----- hdl/ctc_pkg.sv -----
`default_nettype none

package ctc_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  localparam logic [2:0] CMD_WR_DATA   = 3'd0;
  localparam logic [2:0] CMD_WR_CMD    = 3'd1;
  localparam logic [2:0] CMD_RD_DATA   = 3'd2;
  localparam logic [2:0] CMD_RD_STATUS = 3'd3;
  localparam logic [2:0] CMD_LINE_RX   = 3'd4;
  localparam logic [2:0] CMD_LINE_PULL = 3'd5;

  localparam logic [15:0] ST_EXISTS    = 16'h8000;
  localparam logic [15:0] ST_BUSY      = 16'h0100;
  localparam logic [15:0] ST_NOT_READY = 16'h0080;
  localparam logic [15:0] ST_BREAK     = 16'h0020;

  localparam logic [15:0] CW_TYPE      = 16'hC000;
  localparam logic [15:0] CW_CONTROL   = 16'h4000;
  localparam logic [15:0] CW_TRANSFER  = 16'h8000;
  localparam logic [15:0] CW_DI_EN     = 16'h2000;
  localparam logic [15:0] CW_SI_EN     = 16'h1000;
  localparam logic [15:0] CW_READ_DIR  = 16'h0800;
  localparam logic [15:0] CW_TERMINATE = 16'h0400;
  localparam logic [15:0] CW_BRK_SEL   = 16'h0100;
  localparam logic [15:0] CW_BRK_DET   = 16'h0020;
  localparam logic [15:0] CW_SI_REL    = 16'h0004;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] data_word;
    logic [7:0]  line_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        si_request;
    logic        si_clear;
    logic        di_request;
    logic        di_clear;
    logic        bad_command;
    logic        fifo_overflow;
    logic        empty_read;
  } out_word_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] tail_ptr(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] count);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
    if (sum >= (CNT_W + 1)'(FIFO_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(FIFO_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/console_terminal_controller.sv -----
`default_nettype none

// Channel   Ports                          Direction  Payload
// input     in_valid, in_stall, in_word    in         ctc_pkg::in_word_t
// result    out_valid, out_stall, out_word out        ctc_pkg::out_word_t
//
// Every word is accepted into the input register and gives a valid result
// from the result register after the decode and FIFO update; one word is
// accepted per cycle while the result side does not stall.
// FIFO bytes are prefetched at the next head each cycle, with a bypass for
// a byte written at that same edge.
// Reset gives status 0x8080, all flags clear and both FIFOs empty.
// A stall on the result side holds the result and then the input register.

module console_terminal_controller (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  ctc_pkg::in_word_t in_word,
  output logic              out_valid,
  input  wire               out_stall,
  output ctc_pkg::out_word_t out_word
);

  logic                        s1_valid_r;
  ctc_pkg::in_word_t           s1_r;
  logic                        out_valid_r;
  ctc_pkg::out_word_t          out_r;
  logic                        fire;

  logic [15:0]                 status_r, status_nxt;
  logic                        si_en_r, si_en_nxt;
  logic                        di_en_r, di_en_nxt;
  logic                        brk_r, brk_nxt;
  logic                        reading_r, reading_nxt;
  logic                        writing_r, writing_nxt;
  logic [ctc_pkg::CNT_W-1:0]   rx_count_r, rx_count_nxt;
  logic [ctc_pkg::CNT_W-1:0]   tx_count_r, tx_count_nxt;
  logic [ctc_pkg::PTR_W-1:0]   rx_head_r, rx_head_nxt;
  logic [ctc_pkg::PTR_W-1:0]   tx_head_r, tx_head_nxt;

  logic [7:0]                  rx_mem_r [ctc_pkg::FIFO_DEPTH];
  logic [7:0]                  tx_mem_r [ctc_pkg::FIFO_DEPTH];
  logic                        rx_we, tx_we;
  logic [ctc_pkg::PTR_W-1:0]   rx_waddr, tx_waddr;
  logic [7:0]                  rx_rd_r, tx_rd_r;
  logic                        rx_byp_r, tx_byp_r;
  logic [7:0]                  rx_byp_data_r, tx_byp_data_r;
  logic [7:0]                  rx_head_byte, tx_head_byte;
  ctc_pkg::out_word_t          res;

  assign fire      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !fire;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign rx_waddr = ctc_pkg::tail_ptr(rx_head_r, rx_count_r);
  assign tx_waddr = ctc_pkg::tail_ptr(tx_head_r, tx_count_r);
  assign rx_head_byte = rx_byp_r ? rx_byp_data_r : rx_rd_r;
  assign tx_head_byte = tx_byp_r ? tx_byp_data_r : tx_rd_r;

  always_comb begin
    logic [15:0] w;
    logic [15:0] st;
    logic        is_ctrl, is_xfer, noop;
    logic        si_on, di_on, si_set, si_drop, di_set, di_drop;
    logic        need_si, need_di, si_new, di_new;
    w            = s1_r.data_word;
    st           = status_r;
    is_ctrl      = (w & ctc_pkg::CW_TYPE) == ctc_pkg::CW_CONTROL;
    is_xfer      = (w & ctc_pkg::CW_TYPE) == ctc_pkg::CW_TRANSFER;
    noop         = is_ctrl && ((w & ctc_pkg::CW_TERMINATE) == 16'h0000);
    si_on        = (w & ctc_pkg::CW_SI_EN) != 16'h0000;
    di_on        = (w & ctc_pkg::CW_DI_EN) != 16'h0000;
    si_set       = 1'b0;
    si_drop      = 1'b0;
    di_set       = 1'b0;
    di_drop      = 1'b0;
    need_si      = 1'b0;
    need_di      = 1'b0;
    si_new       = si_en_r || si_on;
    di_new       = di_en_r || di_on;
    status_nxt   = status_r;
    si_en_nxt    = si_en_r;
    di_en_nxt    = di_en_r;
    brk_nxt      = brk_r;
    reading_nxt  = reading_r;
    writing_nxt  = writing_r;
    rx_count_nxt = rx_count_r;
    tx_count_nxt = tx_count_r;
    rx_head_nxt  = rx_head_r;
    tx_head_nxt  = tx_head_r;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    res          = '0;
    if (fire) begin
      case (s1_r.cmd)
        ctc_pkg::CMD_WR_DATA: begin
          if (tx_count_r == ctc_pkg::CNT_FULL) begin
            res.fifo_overflow = 1'b1;
          end else begin
            tx_we        = 1'b1;
            tx_count_nxt = tx_count_r + ctc_pkg::CNT_W'(1);
          end
          if (writing_r) begin
            status_nxt = status_r | ctc_pkg::ST_NOT_READY;
          end
        end
        ctc_pkg::CMD_WR_CMD: begin
          if (is_ctrl || is_xfer) begin
            if (noop || is_xfer) begin
              si_set  = si_on && !si_en_r;
              si_drop = !si_on && si_en_r;
              di_set  = di_on && !di_en_r;
              di_drop = !di_on && di_en_r;
            end
            if (is_ctrl && !noop) begin
              reading_nxt = 1'b0;
              writing_nxt = 1'b0;
              need_si     = ((st & ctc_pkg::ST_BUSY) == 16'h0000) && si_en_r;
              st          = (st | ctc_pkg::ST_NOT_READY) & ~ctc_pkg::ST_BUSY;
            end else if (noop) begin
              if ((st & ctc_pkg::ST_BUSY) == 16'h0000) begin
                st = st & ~ctc_pkg::ST_BREAK;
              end
              if ((w & ctc_pkg::CW_BRK_SEL) != 16'h0000) begin
                if ((w & (ctc_pkg::CW_BRK_DET | ctc_pkg::CW_SI_REL)) == 16'h0000) begin
                  brk_nxt = 1'b0;
                end else if ((w & ctc_pkg::CW_BRK_DET) != 16'h0000) begin
                  need_si = !brk_r && si_new;
                  brk_nxt = 1'b1;
                end
                st = st & ~ctc_pkg::ST_BREAK;
              end
            end else begin
              if ((w & ctc_pkg::CW_READ_DIR) == 16'h0000) begin
                need_di     = di_new && !writing_r;
                reading_nxt = 1'b0;
                writing_nxt = 1'b1;
              end else begin
                reading_nxt = 1'b1;
                writing_nxt = 1'b0;
              end
              st = st | ctc_pkg::ST_BUSY;
            end
          end else begin
            res.bad_command = 1'b1;
          end
          if (si_set) begin
            si_en_nxt = 1'b1;
          end else if (si_drop) begin
            si_en_nxt    = 1'b0;
            need_si      = 1'b0;
            res.si_clear = 1'b1;
          end
          if (di_set) begin
            di_en_nxt = 1'b1;
          end else if (di_drop) begin
            di_en_nxt    = 1'b0;
            need_di      = 1'b0;
            res.di_clear = 1'b1;
          end
          if (reading_nxt) begin
            if (rx_count_r == '0) begin
              st = st | ctc_pkg::ST_NOT_READY;
            end else begin
              st = st & ~ctc_pkg::ST_NOT_READY;
            end
          end
          if (writing_nxt) begin
            if (tx_count_r == ctc_pkg::CNT_FULL) begin
              st = st | ctc_pkg::ST_NOT_READY;
            end else begin
              st = st & ~ctc_pkg::ST_NOT_READY;
            end
          end
          status_nxt     = st;
          res.si_request = need_si;
          res.di_request = need_di;
        end
        ctc_pkg::CMD_RD_DATA: begin
          if (rx_count_r == '0) begin
            res.empty_read = 1'b1;
          end else begin
            res.read_data = {8'h00, rx_head_byte};
            rx_head_nxt   = ctc_pkg::ptr_inc(rx_head_r);
            rx_count_nxt  = rx_count_r - ctc_pkg::CNT_W'(1);
          end
          if (reading_r && (rx_count_nxt == '0)) begin
            status_nxt = status_r | ctc_pkg::ST_NOT_READY;
          end
        end
        ctc_pkg::CMD_RD_STATUS: begin
          if (rx_count_r == '0) begin
            st = st | ctc_pkg::ST_NOT_READY;
          end else begin
            st = st & ~ctc_pkg::ST_NOT_READY;
          end
          if (writing_r) begin
            if (tx_count_r != '0) begin
              st = st | ctc_pkg::ST_NOT_READY;
            end else begin
              st = st & ~ctc_pkg::ST_NOT_READY;
            end
          end
          status_nxt    = st;
          res.read_data = st;
        end
        ctc_pkg::CMD_LINE_RX: begin
          if (rx_count_r == ctc_pkg::CNT_FULL) begin
            res.fifo_overflow = 1'b1;
          end else begin
            rx_we        = 1'b1;
            rx_count_nxt = rx_count_r + ctc_pkg::CNT_W'(1);
          end
          status_nxt     = status_r & ~ctc_pkg::ST_NOT_READY;
          res.di_request = di_en_r;
          res.tx_valid   = 1'b1;
          res.tx_byte    = s1_r.line_byte;
        end
        ctc_pkg::CMD_LINE_PULL: begin
          if (tx_count_r != '0) begin
            tx_head_nxt  = ctc_pkg::ptr_inc(tx_head_r);
            tx_count_nxt = tx_count_r - ctc_pkg::CNT_W'(1);
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_head_byte;
            if (writing_r) begin
              status_nxt     = status_r & ~ctc_pkg::ST_NOT_READY;
              res.di_request = di_en_r;
            end
          end else begin
            res.empty_read = 1'b1;
          end
          if (writing_r && (tx_count_nxt == '0)) begin
            status_nxt = status_r & ~ctc_pkg::ST_NOT_READY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ctc_pkg::ST_EXISTS | ctc_pkg::ST_NOT_READY;
      si_en_r     <= 1'b0;
      di_en_r     <= 1'b0;
      brk_r       <= 1'b0;
      reading_r   <= 1'b0;
      writing_r   <= 1'b0;
      rx_count_r  <= '0;
      tx_count_r  <= '0;
      rx_head_r   <= '0;
      tx_head_r   <= '0;
      rx_byp_r    <= 1'b0;
      tx_byp_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      status_r   <= status_nxt;
      si_en_r    <= si_en_nxt;
      di_en_r    <= di_en_nxt;
      brk_r      <= brk_nxt;
      reading_r  <= reading_nxt;
      writing_r  <= writing_nxt;
      rx_count_r <= rx_count_nxt;
      tx_count_r <= tx_count_nxt;
      rx_head_r  <= rx_head_nxt;
      tx_head_r  <= tx_head_nxt;
      rx_byp_r   <= rx_we && (rx_waddr == rx_head_nxt);
      tx_byp_r   <= tx_we && (tx_waddr == tx_head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_r <= in_word;
    end
    if (fire) begin
      out_r <= res;
    end
    rx_byp_data_r <= s1_r.line_byte;
    tx_byp_data_r <= s1_r.data_word[7:0];
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem_r[rx_waddr] <= s1_r.line_byte;
    end
    rx_rd_r <= rx_mem_r[rx_head_nxt];
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem_r[tx_waddr] <= s1_r.data_word[7:0];
    end
    tx_rd_r <= tx_mem_r[tx_head_nxt];
  end

endmodule

`default_nettype wire
